// File: hdl/bsd_pkg.sv
// Shared constants, codes, types and the arctangent table of the bearing and steering unit.
package bsd_pkg;

    // Field widths
    localparam int COORD_BITS       = 15;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int ANG_FRAC         = 16;
    localparam int HEAD_W           = 9;
    localparam int MODE_W           = 2;
    localparam int BEAR_W           = 9;
    localparam int ERR_W            = 9;
    localparam int DIST_W           = 15;
    localparam int SIDE_W           = 2;
    localparam int ARR_W            = 15;
    localparam int BAND_W           = 8;

    // Internal widths
    localparam int DW     = COORD_BITS + 1;
    localparam int ROOT_W = DW;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int XY_W   = COORD_BITS + ANGLE_ITERATIONS + 4;
    localparam int Z_W    = ANG_FRAC + 10;
    localparam int ERR_IW = HEAD_W + 2;
    localparam int NSTAGE = (ANGLE_ITERATIONS > ROOT_W) ? ANGLE_ITERATIONS : ROOT_W;

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_ARRIVAL_RANGE = 1'b0;
    localparam t_reg_idx REG_SIDE_BAND     = 1'b1;
    localparam logic [ARR_W-1:0]  ARRIVAL_RESET = ARR_W'(100);
    localparam logic [BAND_W-1:0] BAND_RESET    = BAND_W'(25);

    // Side classes
    typedef logic [SIDE_W-1:0] t_side_code;
    localparam t_side_code SIDE_ON     = 2'd0;
    localparam t_side_code SIDE_RIGHT  = 2'd1;
    localparam t_side_code SIDE_LEFT   = 2'd2;
    localparam t_side_code SIDE_ROTATE = 2'd3;

    // Skip modes
    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_ALWAYS = 2'd0;
    localparam t_mode MODE_SKIP15 = 2'd1;
    localparam t_mode MODE_SKIP25 = 2'd2;

    localparam int HALF_TURN = 180;
    localparam int FULL_TURN = 360;
    localparam int SKIP_NEAR = 15;
    localparam int SKIP_FAR  = 25;
    localparam int DIST_MAX  = (1 << DIST_W) - 1;

    localparam logic signed [Z_W-1:0] ANG_90  = Z_W'(90 <<< ANG_FRAC);
    localparam logic signed [Z_W-1:0] ANG_180 = Z_W'(180 <<< ANG_FRAC);
    localparam logic signed [Z_W-1:0] ANG_360 = Z_W'(360 <<< ANG_FRAC);

    // atan(2^-i) in degrees, Q16
    function automatic logic signed [Z_W-1:0] atan_q(input int unsigned i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = Z_W'(2949120);
            1:  v = Z_W'(1740967);
            2:  v = Z_W'(919879);
            3:  v = Z_W'(466945);
            4:  v = Z_W'(234379);
            5:  v = Z_W'(117304);
            6:  v = Z_W'(58666);
            7:  v = Z_W'(29335);
            8:  v = Z_W'(14668);
            9:  v = Z_W'(7334);
            10: v = Z_W'(3667);
            11: v = Z_W'(1833);
            12: v = Z_W'(917);
            13: v = Z_W'(458);
            14: v = Z_W'(229);
            15: v = Z_W'(115);
            16: v = Z_W'(57);
            17: v = Z_W'(29);
            18: v = Z_W'(14);
            19: v = Z_W'(7);
            20: v = Z_W'(4);
            21: v = Z_W'(2);
            22: v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        t_mode             mode;
        logic              dx_neg;
        logic              dy_neg;
        logic              ax_zero;
        logic              ay_zero;
    } t_side;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [SQ_W-1:0]        rad;
        logic [ROOT_W+1:0]      rem;
        logic [ROOT_W-1:0]      root;
    } t_core;

    typedef struct packed {
        logic [ARR_W-1:0]  arrival_range;
        logic [BAND_W-1:0] side_band;
    } t_cfg;

endpackage

// File: hdl/bsd_if.sv
// Valid/ready channel interfaces for position items and steering results.
interface bsd_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [bsd_pkg::COORD_BITS-1:0]     cur_x;
    logic signed [bsd_pkg::COORD_BITS-1:0]     cur_y;
    logic signed [bsd_pkg::COORD_BITS-1:0]     target_x;
    logic signed [bsd_pkg::COORD_BITS-1:0]     target_y;
    logic [bsd_pkg::HEAD_W-1:0]                heading;
    logic [bsd_pkg::MODE_W-1:0]                skip_mode;

    modport source (output valid, cur_x, cur_y, target_x, target_y, heading, skip_mode,
                     input ready);
    modport sink   (input valid, cur_x, cur_y, target_x, target_y, heading, skip_mode,
                     output ready);
endinterface

interface bsd_out_if;
    logic                               valid;
    logic                               ready;
    logic [bsd_pkg::BEAR_W-1:0]         bearing;
    logic signed [bsd_pkg::ERR_W-1:0]   turn_error;
    logic [bsd_pkg::DIST_W-1:0]         distance;
    logic                               goal_reached;
    logic [bsd_pkg::SIDE_W-1:0]         side;
    logic                               rotate_request;
    logic                               coincident;

    modport source (output valid, bearing, turn_error, distance, goal_reached, side,
                     rotate_request, coincident, input ready);
    modport sink   (input valid, bearing, turn_error, distance, goal_reached, side,
                     rotate_request, coincident, output ready);
endinterface

// File: hdl/bsd_cfg.sv
// APB-style register file holding arrival range and side band.
module bsd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [bsd_pkg::CFG_AW-1:0]    i_paddr,
    input  logic [bsd_pkg::CFG_DW-1:0]    i_pwdata,
    output logic [bsd_pkg::CFG_DW-1:0]    o_prdata,
    output bsd_pkg::t_cfg                 o_cfg
);
    import bsd_pkg::*;

    logic [ARR_W-1:0]  r_arrival_range;
    logic [BAND_W-1:0] r_side_band;
    t_reg_idx          w_idx;
    logic              w_wr;

    assign w_idx = i_paddr[2:2];
    assign w_wr  = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrival_range <= ARRIVAL_RESET;
            r_side_band     <= BAND_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ARRIVAL_RANGE: r_arrival_range <= i_pwdata[ARR_W-1:0];
                REG_SIDE_BAND:     r_side_band     <= i_pwdata[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ARRIVAL_RANGE: o_prdata = CFG_DW'(r_arrival_range);
            REG_SIDE_BAND:     o_prdata = CFG_DW'(r_side_band);
            default:           o_prdata = '0;
        endcase
    end

    assign o_cfg.arrival_range = r_arrival_range;
    assign o_cfg.side_band     = r_side_band;

endmodule

// File: hdl/bsd_front.sv
// Front stages: offsets and magnitudes, squares, then CORDIC and root seed.
module bsd_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic                                  i_valid,
    input  logic signed [bsd_pkg::COORD_BITS-1:0] i_cur_x,
    input  logic signed [bsd_pkg::COORD_BITS-1:0] i_cur_y,
    input  logic signed [bsd_pkg::COORD_BITS-1:0] i_target_x,
    input  logic signed [bsd_pkg::COORD_BITS-1:0] i_target_y,
    input  logic [bsd_pkg::HEAD_W-1:0]            i_heading,
    input  logic [bsd_pkg::MODE_W-1:0]            i_skip_mode,
    output logic                                  o_valid,
    output bsd_pkg::t_core                        o_core,
    output bsd_pkg::t_side                        o_side
);
    import bsd_pkg::*;

    localparam int PAD = XY_W - ROOT_W - ANGLE_ITERATIONS;

    logic signed [DW-1:0] w_dx, w_dy;
    t_side                n_side1;

    logic                 r1_valid, r2_valid, r3_valid;
    logic [ROOT_W-1:0]    r1_ax, r1_ay, r2_ax, r2_ay;
    t_side                r1_side, r2_side, r3_side;
    logic [SQ_W-1:0]      r2_sqx, r2_sqy;
    t_core                r3_core;

    assign w_dx = DW'(i_target_x) - DW'(i_cur_x);
    assign w_dy = DW'(i_target_y) - DW'(i_cur_y);

    always_comb begin
        n_side1.heading = i_heading;
        n_side1.mode    = i_skip_mode;
        n_side1.dx_neg  = w_dx[DW-1];
        n_side1.dy_neg  = w_dy[DW-1];
        n_side1.ax_zero = (w_dx == '0);
        n_side1.ay_zero = (w_dy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_ax   <= w_dx[DW-1] ? ROOT_W'(-w_dx) : ROOT_W'(w_dx);
            r1_ay   <= w_dy[DW-1] ? ROOT_W'(-w_dy) : ROOT_W'(w_dy);
            r1_side <= n_side1;

            r2_sqx  <= SQ_W'(r1_ax) * SQ_W'(r1_ax);
            r2_sqy  <= SQ_W'(r1_ay) * SQ_W'(r1_ay);
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_side <= r1_side;

            r3_core.x    <= $signed({{PAD{1'b0}}, r2_ax, {ANGLE_ITERATIONS{1'b0}}});
            r3_core.y    <= $signed({{PAD{1'b0}}, r2_ay, {ANGLE_ITERATIONS{1'b0}}});
            r3_core.z    <= '0;
            r3_core.rad  <= r2_sqx + r2_sqy;
            r3_core.rem  <= '0;
            r3_core.root <= '0;
            r3_side      <= r2_side;
        end
    end

    assign o_valid = r3_valid;
    assign o_core  = r3_core;
    assign o_side  = r3_side;

endmodule

// File: hdl/bsd_core.sv
// Unrolled CORDIC vectoring and digit-by-digit square root, one step per stage.
module bsd_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  bsd_pkg::t_core  i_core,
    input  bsd_pkg::t_side  i_side,
    output logic            o_valid,
    output bsd_pkg::t_core  o_core,
    output bsd_pkg::t_side  o_side
);
    import bsd_pkg::*;

    logic  w_valid [NSTAGE+1];
    t_core w_core  [NSTAGE+1];
    t_side w_side  [NSTAGE+1];

    assign w_valid[0] = i_valid;
    assign w_core[0]  = i_core;
    assign w_side[0]  = i_side;

    for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
        t_core n_core;
        t_core r_core;
        t_side r_side;
        logic  r_valid;

        always_comb begin
            logic signed [XY_W-1:0] xs;
            logic signed [XY_W-1:0] ys;
            logic [ROOT_W+1:0]      rem_sh;
            logic [ROOT_W+1:0]      trial;
            n_core = w_core[s];
            xs     = w_core[s].x >>> s;
            ys     = w_core[s].y >>> s;
            rem_sh = {w_core[s].rem[ROOT_W-1:0], w_core[s].rad[SQ_W-1 -: 2]};
            trial  = {w_core[s].root, 2'b01};
            if (s < ANGLE_ITERATIONS) begin
                // rotate towards the X axis
                if (!w_core[s].y[XY_W-1]) begin
                    n_core.x = w_core[s].x + ys;
                    n_core.y = w_core[s].y - xs;
                    n_core.z = w_core[s].z + atan_q(s);
                end else begin
                    n_core.x = w_core[s].x - ys;
                    n_core.y = w_core[s].y + xs;
                    n_core.z = w_core[s].z - atan_q(s);
                end
            end
            if (s < ROOT_W) begin
                // bring down two radicand bits, keep one root bit
                n_core.rad = w_core[s].rad << 2;
                if (rem_sh >= trial) begin
                    n_core.rem  = rem_sh - trial;
                    n_core.root = {w_core[s].root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_core.rem  = rem_sh;
                    n_core.root = {w_core[s].root[ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_adv) begin
                r_valid <= w_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_core <= n_core;
                r_side <= w_side[s];
            end
        end

        assign w_valid[s+1] = r_valid;
        assign w_core[s+1]  = r_core;
        assign w_side[s+1]  = r_side;
    end

    assign o_valid = w_valid[NSTAGE];
    assign o_core  = w_core[NSTAGE];
    assign o_side  = w_side[NSTAGE];

endmodule

// File: hdl/bsd_back.sv
// Back stages: quadrant fold to bearing, distance clamp, then turn error and decisions.
module bsd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  bsd_pkg::t_core                    i_core,
    input  bsd_pkg::t_side                    i_side,
    input  bsd_pkg::t_cfg                     i_cfg,
    output logic                              o_valid,
    output logic [bsd_pkg::BEAR_W-1:0]        o_bearing,
    output logic signed [bsd_pkg::ERR_W-1:0]  o_turn_error,
    output logic [bsd_pkg::DIST_W-1:0]        o_distance,
    output logic                              o_goal_reached,
    output logic [bsd_pkg::SIDE_W-1:0]        o_side,
    output logic                              o_rotate_request,
    output logic                              o_coincident
);
    import bsd_pkg::*;

    logic signed [Z_W-1:0] w_ang, w_full;
    logic [BEAR_W:0]       w_deg;
    logic [BEAR_W-1:0]     n_bearing;
    logic [DIST_W-1:0]     n_dist;
    logic                  w_coin;

    logic                  r1_valid, r2_valid;
    logic [BEAR_W-1:0]     r1_bearing, r2_bearing;
    logic [DIST_W-1:0]     r1_dist, r2_dist;
    logic                  r1_coin, r2_coin;
    logic [HEAD_W-1:0]     r1_heading;
    t_mode                 r1_mode;

    logic signed [ERR_IW-1:0] w_err;
    logic [ERR_IW-1:0]        w_mag;
    t_side_code               n_side;
    logic                     n_rot;

    logic signed [ERR_W-1:0]  r2_err;
    t_side_code               r2_side;
    logic                     r2_rot;
    logic                     r2_goal;

    assign w_coin = i_side.ax_zero && i_side.ay_zero;

    always_comb begin
        // first-quadrant angle, clamped and with the axis cases forced
        if (i_side.ay_zero) begin
            w_ang = '0;
        end else if (i_side.ax_zero) begin
            w_ang = ANG_90;
        end else if (i_core.z < 0) begin
            w_ang = '0;
        end else if (i_core.z > ANG_90) begin
            w_ang = ANG_90;
        end else begin
            w_ang = i_core.z;
        end

        if (!i_side.dx_neg && !i_side.dy_neg) begin
            w_full = w_ang;
        end else if (!i_side.dy_neg) begin
            w_full = ANG_180 - w_ang;
        end else if (i_side.dx_neg || i_side.ax_zero) begin
            w_full = ANG_180 + w_ang;
        end else begin
            w_full = ANG_360 - w_ang;
        end

        w_deg = w_full[ANG_FRAC +: BEAR_W+1];
        // fold a full circle, or a coincident point, to zero
        if (w_coin || (w_deg >= (BEAR_W+1)'(FULL_TURN))) begin
            n_bearing = '0;
        end else begin
            n_bearing = w_deg[BEAR_W-1:0];
        end

        if (i_core.root > ROOT_W'(DIST_MAX)) begin
            n_dist = DIST_W'(DIST_MAX);
        end else begin
            n_dist = i_core.root[DIST_W-1:0];
        end
    end

    always_comb begin
        w_err = $signed({2'b00, r1_bearing}) - $signed({2'b00, r1_heading});
        if (w_err < -HALF_TURN) begin
            w_err = w_err + ERR_IW'(FULL_TURN);
        end
        if (w_err > HALF_TURN) begin
            w_err = w_err - ERR_IW'(FULL_TURN);
        end
        w_mag = w_err[ERR_IW-1] ? ERR_IW'(-w_err) : ERR_IW'(w_err);

        if (w_mag <= ERR_IW'(i_cfg.side_band)) begin
            if (w_err[ERR_IW-1]) begin
                n_side = SIDE_LEFT;
            end else if (w_err != '0) begin
                n_side = SIDE_RIGHT;
            end else begin
                n_side = SIDE_ON;
            end
        end else begin
            n_side = SIDE_ROTATE;
        end

        case (r1_mode)
            MODE_SKIP15: n_rot = (w_mag > ERR_IW'(SKIP_NEAR));
            MODE_SKIP25: n_rot = (w_mag > ERR_IW'(SKIP_FAR));
            default:     n_rot = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_bearing <= n_bearing;
            r1_dist    <= n_dist;
            r1_coin    <= w_coin;
            r1_heading <= i_side.heading;
            r1_mode    <= i_side.mode;

            r2_bearing <= r1_bearing;
            r2_dist    <= r1_dist;
            r2_coin    <= r1_coin;
            r2_err     <= w_err[ERR_W-1:0];
            r2_side    <= n_side;
            r2_rot     <= n_rot;
            r2_goal    <= (r1_dist < i_cfg.arrival_range);
        end
    end

    assign o_valid          = r2_valid;
    assign o_bearing        = r2_bearing;
    assign o_turn_error     = r2_err;
    assign o_distance       = r2_dist;
    assign o_goal_reached   = r2_goal;
    assign o_side           = r2_side;
    assign o_rotate_request = r2_rot;
    assign o_coincident     = r2_coin;

endmodule

// File: hdl/bearing_and_steering_decision_unit.sv
// From accepted transaction to result: three front stages, one stage per CORDIC/root
// step, two back stages. Throughput: one transaction per cycle unless the output stalls;
// the unrolled step pipeline sets the depth.
// A stalled output holds the whole pipeline, so nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and loads arrival_range 100,
// side_band 25; no clearing pass, the block is ready the cycle after reset.
module bearing_and_steering_decision_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bsd_in_if.sink                      i_in,
    bsd_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsd_pkg::CFG_AW-1:0]  paddr,
    input  logic [bsd_pkg::CFG_DW-1:0]  pwdata,
    output logic [bsd_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);
    import bsd_pkg::*;

    logic  w_adv;
    t_cfg  w_cfg;
    logic  w_f_valid, w_c_valid, w_o_valid;
    t_core w_f_core, w_c_core;
    t_side w_f_side, w_c_side;

    // advance while the output register is empty or being taken
    assign w_adv      = !w_o_valid || o_out.ready;
    assign i_in.ready = w_adv;
    assign pready     = 1'b1;
    assign o_out.valid = w_o_valid;

    bsd_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    bsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (i_in.valid),
        .i_cur_x     (i_in.cur_x),
        .i_cur_y     (i_in.cur_y),
        .i_target_x  (i_in.target_x),
        .i_target_y  (i_in.target_y),
        .i_heading   (i_in.heading),
        .i_skip_mode (i_in.skip_mode),
        .o_valid     (w_f_valid),
        .o_core      (w_f_core),
        .o_side      (w_f_side)
    );

    bsd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_f_valid),
        .i_core  (w_f_core),
        .i_side  (w_f_side),
        .o_valid (w_c_valid),
        .o_core  (w_c_core),
        .o_side  (w_c_side)
    );

    bsd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (w_adv),
        .i_valid          (w_c_valid),
        .i_core           (w_c_core),
        .i_side           (w_c_side),
        .i_cfg            (w_cfg),
        .o_valid          (w_o_valid),
        .o_bearing        (o_out.bearing),
        .o_turn_error     (o_out.turn_error),
        .o_distance       (o_out.distance),
        .o_goal_reached   (o_out.goal_reached),
        .o_side           (o_out.side),
        .o_rotate_request (o_out.rotate_request),
        .o_coincident     (o_out.coincident)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the bearing and steering decision unit.
`timescale 1ns / 1ps

module tb;
    import bsd_pkg::*;

    localparam t_mode MODE_UNUSED = 2'd3;
    localparam logic signed [COORD_BITS-1:0] C_MIN = -15'sd16384;
    localparam logic signed [COORD_BITS-1:0] C_MAX = 15'sd16383;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 125;
    localparam int DRAIN_CYCLES = 30;

    // atan(2^-i) in degrees, Q16
    localparam longint ATAN_Q16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cur_x;
        logic signed [COORD_BITS-1:0] cur_y;
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
        logic [HEAD_W-1:0]            heading;
        t_mode                        skip_mode;
    } fix_t;

    typedef struct packed {
        logic [BEAR_W-1:0]        bearing;
        logic signed [ERR_W-1:0]  turn_error;
        logic [DIST_W-1:0]        distance;
        logic                     goal_reached;
        t_side_code               side;
        logic                     rotate_request;
        logic                     coincident;
    } steer_t;

    typedef struct packed {
        fix_t   fix;
        logic   known;
        steer_t want;
    } fix_row_t;

    localparam int NUM_ROWS = 24;

    // Axis and coincident rows carry their result; the rest go through the predictor
    fix_row_t fix_rows [NUM_ROWS] = '{
        '{'{15'sd0, 15'sd0, 15'sd0, 15'sd0, 9'd0, MODE_ALWAYS}, 1'b1,
          '{9'd0, 9'sd0, 15'd0, 1'b1, SIDE_ON, 1'b1, 1'b1}},
        '{'{15'sd0, 15'sd0, 15'sd10, 15'sd0, 9'd0, MODE_SKIP15}, 1'b1,
          '{9'd0, 9'sd0, 15'd10, 1'b1, SIDE_ON, 1'b0, 1'b0}},
        '{'{15'sd0, 15'sd0, 15'sd0, 15'sd50, 9'd90, MODE_SKIP25}, 1'b1,
          '{9'd90, 9'sd0, 15'd50, 1'b1, SIDE_ON, 1'b0, 1'b0}},
        '{'{15'sd0, 15'sd0, -15'sd200, 15'sd0, 9'd170, MODE_SKIP15}, 1'b1,
          '{9'd180, 9'sd10, 15'd200, 1'b0, SIDE_RIGHT, 1'b0, 1'b0}},
        '{'{15'sd0, 15'sd0, 15'sd0, -15'sd99, 9'd300, MODE_SKIP25}, 1'b1,
          '{9'd270, -9'sd30, 15'd99, 1'b1, SIDE_ROTATE, 1'b1, 1'b0}},
        '{'{15'sd0, 15'sd0, 15'sd100, 15'sd0, 9'd200, MODE_UNUSED}, 1'b1,
          '{9'd0, 9'sd160, 15'd100, 1'b0, SIDE_ROTATE, 1'b1, 1'b0}},
        '{'{15'sd5, 15'sd5, 15'sd5, 15'sd5, 9'd511, MODE_SKIP25}, 1'b1,
          '{9'd0, -9'sd151, 15'd0, 1'b1, SIDE_ROTATE, 1'b1, 1'b1}},
        '{'{C_MIN, C_MIN, C_MIN, C_MIN, 9'd359, MODE_SKIP15}, 1'b1,
          '{9'd0, 9'sd1, 15'd0, 1'b1, SIDE_RIGHT, 1'b0, 1'b1}},
        '{'{C_MAX, C_MAX, C_MAX, C_MAX, 9'd180, MODE_ALWAYS}, 1'b1,
          '{9'd0, -9'sd180, 15'd0, 1'b1, SIDE_ROTATE, 1'b1, 1'b1}},
        '{'{15'sd0, 15'sd0, 15'sd0, 15'sd1, 9'd0, MODE_ALWAYS}, 1'b1,
          '{9'd90, 9'sd90, 15'd1, 1'b1, SIDE_ROTATE, 1'b1, 1'b0}},
        '{'{C_MIN, 15'sd0, C_MAX, 15'sd0, 9'd0, MODE_SKIP15}, 1'b1,
          '{9'd0, 9'sd0, 15'd32767, 1'b0, SIDE_ON, 1'b0, 1'b0}},
        '{'{C_MAX, 15'sd0, C_MIN, 15'sd0, 9'd0, MODE_ALWAYS}, 1'b1,
          '{9'd180, 9'sd180, 15'd32767, 1'b0, SIDE_ROTATE, 1'b1, 1'b0}},
        '{'{15'sd0, C_MIN, 15'sd0, C_MAX, 9'd90, MODE_SKIP25}, 1'b1,
          '{9'd90, 9'sd0, 15'd32767, 1'b0, SIDE_ON, 1'b0, 1'b0}},
        '{'{15'sd0, C_MAX, 15'sd0, C_MIN, 9'd270, MODE_SKIP15}, 1'b1,
          '{9'd270, 9'sd0, 15'd32767, 1'b0, SIDE_ON, 1'b0, 1'b0}},
        '{'{C_MIN, C_MIN, C_MAX, C_MAX, 9'd0, MODE_ALWAYS}, 1'b0, '0},
        '{'{C_MAX, C_MAX, C_MIN, C_MIN, 9'd359, MODE_SKIP15}, 1'b0, '0},
        '{'{C_MIN, C_MAX, C_MAX, C_MIN, 9'd511, MODE_UNUSED}, 1'b0, '0},
        '{'{C_MAX, C_MIN, C_MIN, C_MAX, 9'd256, MODE_SKIP25}, 1'b0, '0},
        '{'{15'sd0, 15'sd0, C_MAX, -15'sd1, 9'd0, MODE_SKIP15}, 1'b0, '0},
        '{'{C_MIN, 15'sd0, C_MAX, -15'sd1, 9'd1, MODE_SKIP25}, 1'b0, '0},
        '{'{15'sd0, 15'sd0, C_MIN, 15'sd1, 9'd179, MODE_ALWAYS}, 1'b0, '0},
        '{'{15'sd0, 15'sd0, 15'sd3, 15'sd4, 9'd53, MODE_SKIP15}, 1'b0, '0},
        '{'{15'sd0, 15'sd0, -15'sd7, -15'sd7, 9'd225, MODE_SKIP25}, 1'b0, '0},
        '{'{15'sd0, 15'sd0, 15'sd1, -15'sd1, 9'd315, MODE_ALWAYS}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic pready;

    bsd_in_if  fix_ch ();
    bsd_out_if steer_ch ();

    bearing_and_steering_decision_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (fix_ch),
        .o_out   (steer_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [ARR_W-1:0]  arrival_shadow;
    logic [BAND_W-1:0] band_shadow;
    steer_t            steer_due [$];
    steer_t            head_due;
    int                fault_count = 0;
    int                src_idle = 18;
    int                snk_idle = 55;

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic steer_t predict_steering(input fix_t f);
        longint dx, dy, ax, ay, x, y, z, xs, ys, full, brg, err, mag;
        longint unsigned rest, root, probe;
        int i;
        steer_t r;
        dx = longint'(f.target_x) - longint'(f.cur_x);
        dy = longint'(f.target_y) - longint'(f.cur_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        brg = 0;
        if (dx != 0 || dy != 0) begin
            if (ay == 0) begin
                z = 0;
            end else if (ax == 0) begin
                z = longint'(90) <<< ANG_FRAC;
            end else begin
                x = ax <<< ANGLE_ITERATIONS;
                y = ay <<< ANGLE_ITERATIONS;
                z = 0;
                for (i = 0; i < ANGLE_ITERATIONS; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y >= 0) begin
                        x = x + ys;
                        y = y - xs;
                        z = z + ATAN_Q16[i];
                    end else begin
                        x = x - ys;
                        y = y + xs;
                        z = z - ATAN_Q16[i];
                    end
                end
                if (z < 0) z = 0;
                if (z > (longint'(90) <<< ANG_FRAC)) z = longint'(90) <<< ANG_FRAC;
            end
            if (dx >= 0 && dy >= 0) full = z;
            else if (dy >= 0) full = (longint'(HALF_TURN) <<< ANG_FRAC) - z;
            else if (dx <= 0) full = (longint'(HALF_TURN) <<< ANG_FRAC) + z;
            else full = (longint'(FULL_TURN) <<< ANG_FRAC) - z;
            brg = full >>> ANG_FRAC;
            // fold a full circle back to zero
            if (brg >= FULL_TURN) brg = 0;
        end

        err = brg - longint'(f.heading);
        if (err < -HALF_TURN) err = err + FULL_TURN;
        if (err > HALF_TURN) err = err - FULL_TURN;
        mag = (err < 0) ? -err : err;

        rest = longint'(ax * ax + ay * ay);
        root = 0;
        probe = 64'd1 << 62;
        while (probe > rest) probe = probe >> 2;
        while (probe != 0) begin
            if (rest >= root + probe) begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        if (root > DIST_MAX) root = DIST_MAX;

        r.bearing = brg[BEAR_W-1:0];
        r.turn_error = err[ERR_W-1:0];
        r.distance = root[DIST_W-1:0];
        r.goal_reached = (root < longint'(arrival_shadow));
        if (mag <= longint'(band_shadow))
            r.side = (err > 0) ? SIDE_RIGHT : ((err < 0) ? SIDE_LEFT : SIDE_ON);
        else
            r.side = SIDE_ROTATE;
        case (f.skip_mode)
            MODE_SKIP15: r.rotate_request = (mag > SKIP_NEAR);
            MODE_SKIP25: r.rotate_request = (mag > SKIP_FAR);
            default:     r.rotate_request = 1'b1;
        endcase
        r.coincident = (dx == 0 && dy == 0);
        return r;
    endfunction

    function automatic fix_t random_fix();
        fix_t f;
        int span, off_x, off_y;
        f.cur_x = COORD_BITS'($urandom);
        f.cur_y = COORD_BITS'($urandom);
        f.target_x = COORD_BITS'($urandom);
        f.target_y = COORD_BITS'($urandom);
        case ($urandom_range(2))
            0: span = 4;
            1: span = 128;
            default: span = 4096;
        endcase
        off_x = int'($urandom_range(2 * span)) - span;
        off_y = int'($urandom_range(2 * span)) - span;
        case ($urandom_range(9))
            4, 5: begin
                f.target_x = COORD_BITS'(int'(f.cur_x) + off_x);
                f.target_y = COORD_BITS'(int'(f.cur_y) + off_y);
            end
            6: f.target_x = f.cur_x;
            7: f.target_y = f.cur_y;
            8: begin
                f.target_x = f.cur_x;
                f.target_y = f.cur_y;
            end
            9: begin
                // one tiny component against a random one, near the axes and the wrap
                f.target_y = COORD_BITS'(int'(f.cur_y) + int'($urandom_range(2)) - 1);
            end
            default: ;
        endcase
        if ($urandom_range(99) < 85)
            f.heading = HEAD_W'($urandom_range(FULL_TURN - 1));
        else
            f.heading = HEAD_W'($urandom_range(511, FULL_TURN));
        f.skip_mode = MODE_W'($urandom_range(3));
        return f;
    endfunction

    task automatic cmp_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    // Result side: check every transaction, then draw the next ready
    always @(posedge clk) begin
        if (rst_n && steer_ch.valid && steer_ch.ready) begin
            if (steer_due.size() == 0) begin
                $error("result transaction with nothing outstanding");
                fault_count++;
            end else begin
                head_due = steer_due.pop_front();
                cmp_field("bearing", 64'(head_due.bearing), 64'(steer_ch.bearing));
                cmp_field("turn_error", 64'(head_due.turn_error), 64'(steer_ch.turn_error));
                cmp_field("distance", 64'(head_due.distance), 64'(steer_ch.distance));
                cmp_field("goal_reached", 64'(head_due.goal_reached),
                          64'(steer_ch.goal_reached));
                cmp_field("side", 64'(head_due.side), 64'(steer_ch.side));
                cmp_field("rotate_request", 64'(head_due.rotate_request),
                          64'(steer_ch.rotate_request));
                cmp_field("coincident", 64'(head_due.coincident), 64'(steer_ch.coincident));
            end
        end
        steer_ch.ready <= ($urandom_range(99) >= snk_idle);
    end

    task automatic send_fix(input fix_t f, input logic known, input steer_t want);
        while ($urandom_range(99) < src_idle) begin
            fix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        fix_ch.valid    <= 1'b1;
        fix_ch.cur_x    <= f.cur_x;
        fix_ch.cur_y    <= f.cur_y;
        fix_ch.target_x <= f.target_x;
        fix_ch.target_y <= f.target_y;
        fix_ch.heading  <= f.heading;
        fix_ch.skip_mode <= f.skip_mode;
        @(posedge clk);
        while (!fix_ch.ready) @(posedge clk);
        steer_due.push_back(known ? want : predict_steering(f));
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [CFG_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // idle between transfers
        @(posedge clk);
    endtask

    task automatic check_reg(input t_reg_idx idx, input logic [CFG_DW-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        cmp_field(idx == REG_ARRIVAL_RANGE ? "arrival_range" : "side_band",
                  64'(want), 64'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Drain the pipeline, then load both registers and read them back
    task automatic apply_settings(input logic [ARR_W-1:0] arr, input logic [BAND_W-1:0] bnd);
        fix_ch.valid <= 1'b0;
        while (steer_due.size() != 0) @(posedge clk);
        cfg_write(REG_ARRIVAL_RANGE, CFG_DW'(arr));
        arrival_shadow = arr;
        cfg_write(REG_SIDE_BAND, CFG_DW'(bnd));
        band_shadow = bnd;
        check_reg(REG_ARRIVAL_RANGE, CFG_DW'(arr));
        check_reg(REG_SIDE_BAND, CFG_DW'(bnd));
    endtask

    initial begin
        #2_000_000;
        $display("bearing_and_steering_decision_unit verification failed");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fix_ch.valid = 1'b0;
        fix_ch.cur_x = '0;
        fix_ch.cur_y = '0;
        fix_ch.target_x = '0;
        fix_ch.target_y = '0;
        fix_ch.heading = '0;
        fix_ch.skip_mode = MODE_ALWAYS;
        steer_ch.ready = 1'b0;
        arrival_shadow = ARRIVAL_RESET;
        band_shadow = BAND_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reg(REG_ARRIVAL_RANGE, CFG_DW'(ARRIVAL_RESET));
        check_reg(REG_SIDE_BAND, CFG_DW'(BAND_RESET));

        for (int r = 0; r < NUM_ROWS; r++)
            send_fix(fix_rows[r].fix, fix_rows[r].known, fix_rows[r].want);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: apply_settings('0, '0);
                1: apply_settings(ARR_W'(DIST_MAX), BAND_W'(HALF_TURN));
                2: apply_settings(ARR_W'($urandom_range(DIST_MAX)), '1);
                3: apply_settings(ARR_W'($urandom_range(DIST_MAX)),
                                  BAND_W'($urandom_range(HALF_TURN)));
                4: apply_settings(ARR_W'(1), BAND_W'(SKIP_NEAR));
                default: apply_settings(ARRIVAL_RESET, BAND_RESET);
            endcase
            // receiver-heavy idling, then sender-heavy, then none
            if (ph < 2) begin
                src_idle = 18;
                snk_idle = 55;
            end else if (ph < 4) begin
                src_idle = 55;
                snk_idle = 18;
            end else begin
                src_idle = 0;
                snk_idle = 0;
            end
            repeat (PHASE_ITEMS) send_fix(random_fix(), 1'b0, '0);
        end

        fix_ch.valid <= 1'b0;
        while (steer_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("bearing_and_steering_decision_unit verification clean");
        else
            $display("bearing_and_steering_decision_unit verification failed");
        $finish;
    end

endmodule
